// ----- rtl/directed_graph_adjacency_store_top_defines.svh -----
// Assertion macros used by the graph store datapath.
`ifndef DIRECTED_GRAPH_ADJACENCY_STORE_TOP_DEFINES_SVH
`define DIRECTED_GRAPH_ADJACENCY_STORE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define DGA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("graph store assertion failed");
// Condition must never be seen at a clock edge out of reset.
`define DGA_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("graph store forbidden condition seen");
`else
`define DGA_ASSERT(label, clk, rst_n, prop)
`define DGA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- rtl/dga_pkg.sv -----
// Types, constants and command/status bundles of the graph store.
`default_nettype none

package dga_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int LABEL_W    = 8;
    localparam int STATUS_W   = 3;

    // Graph geometry
    localparam int NUM_LABELS    = 256;
    localparam int LABEL_SPACE   = 2 ** LABEL_W;
    localparam int WORD_W        = 64;
    localparam int BIT_SEL_W     = $clog2(WORD_W);
    localparam int WORDS_PER_ROW = LABEL_SPACE / WORD_W;
    localparam int WORD_SEL_W    = $clog2(WORDS_PER_ROW);
    localparam int MEM_DEPTH     = LABEL_SPACE * WORDS_PER_ROW;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int ROW_CNT_W     = $clog2(NUM_LABELS + 1);

    // Stream widths
    localparam int S_TDATA_W = ((OP_W + 2 * LABEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_VERTEX = 2'd0,
        OP_DEL_VERTEX = 2'd1,
        OP_ADD_ARC    = 2'd2,
        OP_DEL_ARC    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EXISTS      = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_VMISSING    = 3'd3,
        ST_SRCMISSING  = 3'd4,
        ST_DSTMISSING  = 3'd5,
        ST_NOARC       = 3'd6
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    accept;
        logic    vertex_add;
        logic    vertex_del;
        logic    status_we;
        t_status status_code;
        logic    arc_read;
        logic    arc_write;
        logic    clr_step;
        logic    row_clr_step;
        logic    sweep_step;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic a_in_range;
        logic a_present;
        logic b_present;
        logic count_zero;
        logic arc_bit;
        logic clr_last;
        logic row_clr_last;
        logic sweep_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/dga_ctrl.sv -----
// Operation sequencer of the graph store.
`default_nettype none

module dga_ctrl
    import dga_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_DECIDE  = 7'b0000100,
        S_MODIFY  = 7'b0001000,
        S_ROW_CLR = 7'b0010000,
        S_SWEEP   = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Advance state; reset starts the memory clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode state and datapath status into commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_sts.op)
                    OP_ADD_VERTEX: begin
                        o_cmd.status_we = 1'b1;
                        n_state         = S_DONE;
                        if (!i_sts.a_in_range) begin
                            o_cmd.status_code = ST_VMISSING;
                        end else if (i_sts.a_present) begin
                            o_cmd.status_code = ST_EXISTS;
                        end else begin
                            o_cmd.status_code = ST_OK;
                            o_cmd.vertex_add  = 1'b1;
                        end
                    end
                    OP_DEL_VERTEX: begin
                        if (i_sts.count_zero) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = ST_EMPTY;
                            n_state           = S_DONE;
                        end else if (!i_sts.a_present) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = ST_VMISSING;
                            n_state           = S_DONE;
                        end else begin
                            n_state = S_ROW_CLR;
                        end
                    end
                    OP_ADD_ARC: begin
                        if (!i_sts.a_present) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = ST_SRCMISSING;
                            n_state           = S_DONE;
                        end else if (!i_sts.b_present) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = ST_DSTMISSING;
                            n_state           = S_DONE;
                        end else begin
                            o_cmd.arc_read = 1'b1;
                            n_state        = S_MODIFY;
                        end
                    end
                    default: begin
                        if (!i_sts.a_present) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = ST_SRCMISSING;
                            n_state           = S_DONE;
                        end else begin
                            o_cmd.arc_read = 1'b1;
                            n_state        = S_MODIFY;
                        end
                    end
                endcase
            end
            S_MODIFY: begin
                // Word is back from memory: set or clear the arc bit
                o_cmd.status_we = 1'b1;
                n_state         = S_DONE;
                if (i_sts.op == OP_DEL_ARC && !i_sts.arc_bit) begin
                    o_cmd.status_code = ST_NOARC;
                end else begin
                    o_cmd.status_code = ST_OK;
                    o_cmd.arc_write   = 1'b1;
                end
            end
            S_ROW_CLR: begin
                o_cmd.row_clr_step = 1'b1;
                if (i_sts.row_clr_last) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (i_sts.sweep_done) begin
                    o_cmd.vertex_del  = 1'b1;
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = ST_OK;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/dga_datapath.sv -----
// Vertex bitmap, adjacency memory, sweep counters and result register.
`default_nettype none
`include "directed_graph_adjacency_store_top_defines.svh"

module dga_datapath
    import dga_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata
);

    // Adjacency memory: row = source label, bit = destination label
    logic [WORD_W-1:0] mem [MEM_DEPTH];

    // Latched operation
    t_op                r_op;
    logic [LABEL_W-1:0] r_a;
    logic [LABEL_W-1:0] r_b;

    // Vertex state
    logic [LABEL_SPACE-1:0] r_present;
    logic [ROW_CNT_W-1:0]   r_count;

    // Sequencing counters
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [WORD_SEL_W-1:0] r_k;
    logic [ROW_CNT_W-1:0]  r_row;
    logic                  r_wb_valid;
    logic [ADDR_W-1:0]     r_wb_addr;

    // Memory read data and result
    logic [WORD_W-1:0] r_rd_data;
    t_status           r_status;
    logic              r_out_valid;
    t_status           r_out_status;

    // Memory port controls
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [ADDR_W-1:0] arc_addr;
    logic [ADDR_W-1:0] sweep_raddr;
    logic [WORD_W-1:0] arc_mask;
    logic [WORD_W-1:0] col_mask;
    logic              row_active;
    logic              a_in_range;
    logic              b_in_range;

    localparam logic [LABEL_W:0] LABEL_LIMIT = (LABEL_W + 1)'(NUM_LABELS);

    // Derive addresses, masks and range checks
    always_comb begin
        a_in_range  = {1'b0, r_a} < LABEL_LIMIT;
        b_in_range  = {1'b0, r_b} < LABEL_LIMIT;
        arc_addr    = {r_a, r_b[LABEL_W-1 -: WORD_SEL_W]};
        sweep_raddr = {LABEL_W'(r_row), r_a[LABEL_W-1 -: WORD_SEL_W]};
        arc_mask    = WORD_W'(1) << r_b[BIT_SEL_W-1:0];
        col_mask    = WORD_W'(1) << r_a[BIT_SEL_W-1:0];
        row_active  = r_row < ROW_CNT_W'(NUM_LABELS);
    end

    // Select the memory write and read sources
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = arc_addr;
        if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
        end else if (i_cmd.row_clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = {r_a, r_k};
        end else if (i_cmd.arc_write) begin
            mem_we    = 1'b1;
            mem_waddr = arc_addr;
            if (r_op == OP_ADD_ARC) begin
                mem_wdata = r_rd_data | arc_mask;
            end else begin
                mem_wdata = r_rd_data & ~arc_mask;
            end
        end else if (i_cmd.sweep_step && r_wb_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_wb_addr;
            mem_wdata = r_rd_data & ~col_mask;
        end
        if (i_cmd.arc_read) begin
            mem_re    = 1'b1;
            mem_raddr = arc_addr;
        end else if (i_cmd.sweep_step && row_active) begin
            mem_re    = 1'b1;
            mem_raddr = sweep_raddr;
        end
    end

    // Write and read the adjacency memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // Hold the operation and the status of the current transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= t_op'(i_s_tdata[OP_W-1:0]);
            r_a  <= i_s_tdata[OP_W +: LABEL_W];
            r_b  <= i_s_tdata[OP_W + LABEL_W +: LABEL_W];
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.sweep_step) begin
            r_wb_addr <= sweep_raddr;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
        end
    end

    // Update vertex bitmap, counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_row       <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.vertex_add) begin
                r_present[r_a] <= 1'b1;
                r_count        <= r_count + 1'b1;
            end else if (i_cmd.vertex_del) begin
                r_present[r_a] <= 1'b0;
                r_count        <= r_count - 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.accept) begin
                r_k <= '0;
            end else if (i_cmd.row_clr_step) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.row_clr_step) begin
                r_row      <= '0;
                r_wb_valid <= 1'b0;
            end else if (i_cmd.sweep_step) begin
                r_wb_valid <= row_active;
                if (row_active) begin
                    r_row <= r_row + 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Report status to the controller
    always_comb begin
        o_sts.op           = r_op;
        o_sts.a_in_range   = a_in_range;
        o_sts.a_present    = a_in_range && r_present[r_a];
        o_sts.b_present    = b_in_range && r_present[r_b];
        o_sts.count_zero   = (r_count == '0);
        o_sts.arc_bit      = r_rd_data[r_b[BIT_SEL_W-1:0]];
        o_sts.clr_last     = (r_clr_addr == ADDR_W'(MEM_DEPTH - 1));
        o_sts.row_clr_last = (r_k == WORD_SEL_W'(WORDS_PER_ROW - 1));
        o_sts.sweep_done   = !row_active && !r_wb_valid;
        o_sts.out_free     = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_status);

    // Vertex count always matches the bitmap population
    `DGA_ASSERT(a_count_matches, i_clk, i_rst_n, $countones(r_present) == int'(r_count))
    // Sweep write-back never collides with the row being read
    `DGA_ASSERT_NEVER(a_no_rw_clash, i_clk, i_rst_n, mem_we && mem_re && mem_waddr == mem_raddr)
    // Arc words are only modified for a present source
    `DGA_ASSERT(a_arc_src_present, i_clk, i_rst_n, !i_cmd.arc_write || r_present[r_a])
    // A result waiting to be taken is never overwritten
    `DGA_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load && r_out_valid && !i_m_tready)

endmodule

`default_nettype wire

// ----- rtl/directed_graph_adjacency_store_top.sv -----
// Directed graph store: stream ports around the sequencer and the datapath.
// Vertex adds, vertex removal misses and missing arc ends go from decision straight to result.
// Arc add or remove first reads the arc word; a vertex removal clears the source row, then sweeps
// every row, writing back each read row with the column cleared while the next row is read.
// One transaction is worked at a time; the next is taken once the result is registered.
// Synchronous active-low reset, then a pass clearing all 1024 memory words before input is taken.
`default_nettype none

module directed_graph_adjacency_store_top
    import dga_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // op[1:0], first_label[9:2], second_label[17:10]
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata   // status[2:0]
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dga_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dga_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/directed_graph_adjacency_store_checker.sv -----
// Checker for the graph store: predicts each status and compares the result stream.
module directed_graph_adjacency_store_checker
    import dga_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // op[1:0], first_label[9:2], second_label[17:10]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,  // status[2:0]
    output int                   o_fail_count,
    output int                   o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_op                op;
        logic [LABEL_W-1:0] src;
        logic [LABEL_W-1:0] dst;
        t_status            status;
    } t_status_due;

    // Shadow graph: one presence bit per label, one arc row per source label
    bit [LABEL_SPACE-1:0] vertex_live = '0;
    bit [LABEL_SPACE-1:0] arc_row [LABEL_SPACE];
    logic [8:0]           live_count = '0;

    t_status_due status_due_q [$];
    int          mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    function automatic bit is_live(logic [LABEL_W-1:0] label);
        return (int'(label) < NUM_LABELS) && vertex_live[label];
    endfunction

    // Apply one operation to the shadow graph and return its status
    function automatic t_status apply_graph_op(t_op op, logic [LABEL_W-1:0] src,
                                               logic [LABEL_W-1:0] dst);
        t_status st;
        st = ST_OK;
        case (op)
            OP_ADD_VERTEX: begin
                if (int'(src) >= NUM_LABELS) begin
                    st = ST_VMISSING;
                end else if (vertex_live[src]) begin
                    st = ST_EXISTS;
                end else begin
                    vertex_live[src] = 1'b1;
                    live_count = live_count + 9'd1;
                end
            end
            OP_DEL_VERTEX: begin
                if (live_count == '0) begin
                    st = ST_EMPTY;
                end else if (!is_live(src)) begin
                    st = ST_VMISSING;
                end else begin
                    // drop the outgoing row, then the column across every row
                    arc_row[src] = '0;
                    for (int r = 0; r < NUM_LABELS; r++) begin
                        arc_row[r][src] = 1'b0;
                    end
                    vertex_live[src] = 1'b0;
                    live_count = live_count - 9'd1;
                end
            end
            OP_ADD_ARC: begin
                if (!is_live(src)) begin
                    st = ST_SRCMISSING;
                end else if (!is_live(dst)) begin
                    st = ST_DSTMISSING;
                end else begin
                    arc_row[src][dst] = 1'b1;
                end
            end
            default: begin
                if (!is_live(src)) begin
                    st = ST_SRCMISSING;
                end else if (!arc_row[src][dst]) begin
                    st = ST_NOARC;
                end else begin
                    arc_row[src][dst] = 1'b0;
                end
            end
        endcase
        return st;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_total < 50) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        mismatch_total++;
    endtask

    // Compare outgoing results first, then predict the incoming transaction
    always @(posedge i_clk) begin
        t_status_due due;
        t_status_due fresh;
        if (!i_rst_n) begin
            vertex_live = '0;
            for (int r = 0; r < LABEL_SPACE; r++) begin
                arc_row[r] = '0;
            end
            live_count = '0;
            status_due_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (status_due_q.size() == 0) begin
                    report_mismatch($sformatf("result status %0d with nothing outstanding",
                                              i_m_tdata[STATUS_W-1:0]));
                end else begin
                    due = status_due_q.pop_front();
                    if (i_m_tdata[STATUS_W-1:0] !== due.status) begin
                        report_mismatch($sformatf("%s %0d,%0d: status %0d, want %0d",
                                                  due.op.name(), due.src, due.dst,
                                                  i_m_tdata[STATUS_W-1:0], due.status));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fresh.op     = t_op'(i_s_tdata[OP_W-1:0]);
                fresh.src    = i_s_tdata[OP_W +: LABEL_W];
                fresh.dst    = i_s_tdata[OP_W+LABEL_W +: LABEL_W];
                fresh.status = apply_graph_op(fresh.op, fresh.src, fresh.dst);
                status_due_q.push_back(fresh);
            end
        end
        o_pending <= status_due_q.size();
    end

endmodule

// ----- tb/tb_directed_graph_adjacency_store_top.sv -----
// Testbench top for the graph store: clock, reset, stream stimulus and the verdict.
module tb_directed_graph_adjacency_store_top;

    timeunit 1ns;
    timeprecision 1ps;

    import dga_pkg::*;

    localparam int RANDOM_OPS  = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 36;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // op[1:0], first_label[9:2], second_label[17:10]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // status[2:0]

    int fail_count;
    int pending;

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;

    int label_pool [64];
    int pool_n = 1;

    directed_graph_adjacency_store_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    directed_graph_adjacency_store_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    // Offer one operation, with random gaps ahead of it, and hold it until taken
    task automatic send_op(input t_op op, input logic [LABEL_W-1:0] src,
                           input logic [LABEL_W-1:0] dst);
        while (tx_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - OP_W - 2 * LABEL_W){1'b0}}, dst, src, op};
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
    endtask

    function automatic logic [LABEL_W-1:0] pick_label();
        if ($urandom_range(0, 99) < 80) begin
            return LABEL_W'(label_pool[$urandom_range(0, pool_n - 1)]);
        end
        return LABEL_W'($urandom_range(0, LABEL_SPACE - 1));
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_gaps && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin
        int  pick;
        t_op op;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty graph, duplicates, missing ends, self arc, vertex removal sweep
        send_op(OP_DEL_VERTEX, 8'd5,   8'd255);
        send_op(OP_DEL_ARC,    8'd0,   8'd0);
        send_op(OP_ADD_ARC,    8'd0,   8'd255);
        send_op(OP_ADD_VERTEX, 8'd0,   8'd0);
        send_op(OP_ADD_VERTEX, 8'd255, 8'd255);
        send_op(OP_ADD_VERTEX, 8'd0,   8'd170);
        send_op(OP_DEL_VERTEX, 8'd17,  8'd85);
        send_op(OP_ADD_ARC,    8'd0,   8'd255);
        send_op(OP_ADD_ARC,    8'd0,   8'd255);
        send_op(OP_ADD_ARC,    8'd0,   8'd17);
        send_op(OP_ADD_ARC,    8'd255, 8'd255);
        send_op(OP_DEL_ARC,    8'd0,   8'd17);
        send_op(OP_DEL_ARC,    8'd17,  8'd0);
        send_op(OP_ADD_ARC,    8'd255, 8'd0);
        send_op(OP_DEL_ARC,    8'd0,   8'd255);
        send_op(OP_DEL_ARC,    8'd0,   8'd255);
        send_op(OP_ADD_ARC,    8'd0,   8'd255);
        send_op(OP_DEL_VERTEX, 8'd255, 8'd0);
        send_op(OP_DEL_ARC,    8'd0,   8'd255);
        send_op(OP_ADD_VERTEX, 8'd255, 8'd0);
        send_op(OP_DEL_ARC,    8'd255, 8'd255);
        send_op(OP_DEL_ARC,    8'd255, 8'd0);
        send_op(OP_DEL_VERTEX, 8'd0,   8'd255);
        send_op(OP_DEL_VERTEX, 8'd255, 8'd0);
        send_op(OP_DEL_VERTEX, 8'd255, 8'd255);

        // Random: labels mostly from a small working set so arcs and hits build up
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 150 == 0) begin
                pool_n = $urandom_range(2, 40);
                for (int k = 0; k < pool_n; k++) begin
                    label_pool[k] = $urandom_range(0, LABEL_SPACE - 1);
                end
            end
            if (n == 300) begin
                hold_req = 1'b1;
            end
            tx_gaps = !(n >= 600 && n < 900);
            rx_gaps = tx_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                op = OP_ADD_VERTEX;
            end else if (pick < 42) begin
                op = OP_DEL_VERTEX;
            end else if (pick < 75) begin
                op = OP_ADD_ARC;
            end else begin
                op = OP_DEL_ARC;
            end
            send_op(op, pick_label(), pick_label());
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for a full vertex removal worth of cycles
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("directed_graph_adjacency_store_top verification clean");
        end else begin
            $display("directed_graph_adjacency_store_top verification failed");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("directed_graph_adjacency_store_top verification failed");
        $finish;
    end

endmodule
